[sv/llsem_pkg.sv]
// Shared constants, types and helper functions for the log line session end matcher.
// Used by every module of the block; depends on nothing else.
package llsem_pkg;

    localparam int MAX_LINE      = 32768;
    localparam int MAX_ID_DIGITS = 16;

    localparam int LEN_W  = $clog2(MAX_LINE);
    localparam int ID_W   = 64;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic [7:0] LF_BYTE  = 8'h0a;
    localparam logic [7:0] TAG_BYTE = 8'h53;
    localparam logic [LEN_W-1:0] COL_OF_TAG = LEN_W'(20);
    localparam logic [LEN_W-1:0] LAST_COL   = LEN_W'(MAX_LINE - 1);
    localparam logic [IDX_W-1:0] END_TEXT_LEN = IDX_W'(14);
    localparam logic [CNT_W-1:0] ID_DIGITS_MAX = CNT_W'(MAX_ID_DIGITS);
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - 4 * MAX_ID_DIGITS);

    typedef enum logic [5:0] {
        PH_COLUMN = 6'b000001,
        PH_PRE_WS = 6'b000010,
        PH_DIGITS = 6'b000100,
        PH_GAP    = 6'b001000,
        PH_TEXT   = 6'b010000,
        PH_REJECT = 6'b100000
    } t_phase;

    typedef struct packed {
        logic             end_of_session;
        logic [ID_W-1:0]  session_id_bcd;
        logic [CNT_W-1:0] id_digits;
        logic             id_too_long;
    } t_result;

    function automatic logic [7:0] end_text_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h45;
            4'd1:    c = 8'h6e;
            4'd2:    c = 8'h64;
            4'd3:    c = 8'h20;
            4'd4:    c = 8'h6f;
            4'd5:    c = 8'h66;
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h73;
            4'd8:    c = 8'h65;
            4'd9:    c = 8'h73;
            4'd10:   c = 8'h73;
            4'd11:   c = 8'h69;
            4'd12:   c = 8'h6f;
            4'd13:   c = 8'h6e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

[sv/llsem_in_reg.sv]
// Input register that holds one text byte until the parser takes it.
// Depends on llsem_pkg.
module llsem_in_reg
    import llsem_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[sv/llsem_parser.sv]
// Line parser state machine: column count, session id capture and text match.
// Depends on llsem_pkg; produces the result for the line ended by an LF.
module llsem_parser
    import llsem_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [ID_W-1:0]  r_id, n_id;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             hit;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_id    = r_id;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        if (i_take) begin
            if (i_byte == LF_BYTE || r_len == LAST_COL) begin
                n_phase = PH_COLUMN;
                n_len   = '0;
                n_idx   = '0;
                n_id    = '0;
                n_cnt   = '0;
                n_ovf   = 1'b0;
            end else begin
                n_len = r_len + LEN_W'(1);
                case (r_phase)
                    PH_COLUMN: begin
                        if (i_byte == 8'h00) begin
                            n_phase = PH_REJECT;
                        end else if (r_len == COL_OF_TAG) begin
                            n_phase = (i_byte == TAG_BYTE) ? PH_PRE_WS : PH_REJECT;
                        end
                    end
                    PH_PRE_WS, PH_DIGITS: begin
                        if (is_digit(i_byte)) begin
                            n_phase = PH_DIGITS;
                            n_id    = {r_id[ID_W-5:0], i_byte[3:0]} & ID_MASK;
                            if (r_cnt < ID_DIGITS_MAX) begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else if (is_ws(i_byte)) begin
                            if (r_phase == PH_DIGITS) begin
                                n_phase = PH_GAP;
                            end
                        end else begin
                            n_phase = PH_REJECT;
                        end
                    end
                    PH_GAP: begin
                        if (!is_ws(i_byte)) begin
                            if (i_byte == end_text_char('0)) begin
                                n_phase = PH_TEXT;
                                n_idx   = IDX_W'(1);
                            end else begin
                                n_phase = PH_REJECT;
                            end
                        end
                    end
                    PH_TEXT: begin
                        if (r_idx < END_TEXT_LEN) begin
                            if (i_byte == end_text_char(r_idx)) begin
                                n_idx = r_idx + IDX_W'(1);
                            end else begin
                                n_phase = PH_REJECT;
                            end
                        end else if (!is_ws(i_byte)) begin
                            n_phase = PH_REJECT;
                        end
                    end
                    default: begin
                        n_phase = PH_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLUMN;
            r_len   <= '0;
            r_idx   <= '0;
            r_id    <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_id    <= n_id;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    assign hit = (r_phase == PH_TEXT) && (r_idx == END_TEXT_LEN);

    always_comb begin
        o_res.end_of_session = hit;
        o_res.session_id_bcd = hit ? r_id : '0;
        o_res.id_digits      = hit ? r_cnt : '0;
        o_res.id_too_long    = hit && r_ovf;
    end

endmodule

[sv/llsem_out_reg.sv]
// Result register that holds one line result until the consumer takes it.
// Depends on llsem_pkg for the result type.
module llsem_out_reg
    import llsem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_full = r_valid && i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[sv/log_line_session_end_matcher_core.sv]
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_text_byte
// out       output     o_out_valid / i_out_stall  o_end_of_session, o_session_id_bcd,
//                                                 o_id_digits, o_id_too_long
// One byte is taken every cycle while no LF waits behind a stalled result; each byte
// passes the input register, then the parser; a taken LF loads the output register.
// Synchronous active-low reset empties both registers and returns the parser to column 0.
// A stalled result holds the output; only an LF waiting behind it stalls the input.
// Depends on llsem_pkg, llsem_in_reg, llsem_parser and llsem_out_reg.
module log_line_session_end_matcher_core
    import llsem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_text_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_end_of_session,
    output logic [ID_W-1:0]  o_session_id_bcd,
    output logic [CNT_W-1:0] o_id_digits,
    output logic             o_id_too_long
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       out_full;
    logic       is_lf;
    t_result    parse_res;
    t_result    out_res;

    assign is_lf = (byte_data == LF_BYTE);
    assign take  = byte_valid && !(is_lf && out_full);

    llsem_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_text_byte),
        .i_take  (take),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    llsem_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (byte_data),
        .o_res   (parse_res)
    );

    llsem_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && is_lf),
        .i_res   (parse_res),
        .o_full  (out_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_end_of_session = out_res.end_of_session;
    assign o_session_id_bcd = out_res.session_id_bcd;
    assign o_id_digits      = out_res.id_digits;
    assign o_id_too_long    = out_res.id_too_long;

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_end_of_session |->
            o_session_id_bcd == '0 && o_id_digits == '0 && !o_id_too_long)
        else $error("non-matching line carries id fields");

    a_hit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_session |->
            o_id_digits != '0 && o_id_digits <= ID_DIGITS_MAX)
        else $error("matching line has a bad digit count");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_id_too_long |-> o_id_digits == ID_DIGITS_MAX)
        else $error("id overflow without a full digit count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byte_valid && is_lf && out_full |=> byte_valid && is_lf)
        else $error("line end lost while the output was stalled");

endmodule

[dv/log_line_session_end_matcher_core_tb.sv]
// Self-checking testbench for log_line_session_end_matcher_core: sends text lines byte by byte,
// predicts the verdict of every finished line and compares each output transaction with it.
// Depends on llsem_pkg and the log_line_session_end_matcher_core RTL.
module log_line_session_end_matcher_core_tb
    import llsem_pkg::*;
();

    localparam int IDLE_LIMIT = 4000;
    localparam logic [8*14-1:0] SESSION_END_TEXT = "End of session";

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic [7:0]       i_text_byte = 8'h00;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_end_of_session;
    logic [ID_W-1:0]  o_session_id_bcd;
    logic [CNT_W-1:0] o_id_digits;
    logic             o_id_too_long;

    t_result          pending_verdicts[$];
    logic [7:0]       line_bytes[$];
    int               mismatches = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               quiet_cycles = 0;

    t_phase           line_phase;
    int               col_count;
    int               text_idx;
    logic [ID_W-1:0]  id_bcd;
    logic [CNT_W-1:0] id_cnt;
    logic             id_ovf;

    log_line_session_end_matcher_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_end_of_session (o_end_of_session),
        .o_session_id_bcd (o_session_id_bcd),
        .o_id_digits      (o_id_digits),
        .o_id_too_long    (o_id_too_long)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("log_line_session_end_matcher_core_tb failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected line result transaction");
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_end_of_session !== want.end_of_session) begin
                    $error("end_of_session: expected %0h, actual %0h",
                           want.end_of_session, o_end_of_session);
                    mismatches++;
                end
                if (o_session_id_bcd !== want.session_id_bcd) begin
                    $error("session_id_bcd: expected %0h, actual %0h",
                           want.session_id_bcd, o_session_id_bcd);
                    mismatches++;
                end
                if (o_id_digits !== want.id_digits) begin
                    $error("id_digits: expected %0d, actual %0d", want.id_digits, o_id_digits);
                    mismatches++;
                end
                if (o_id_too_long !== want.id_too_long) begin
                    $error("id_too_long: expected %0h, actual %0h",
                           want.id_too_long, o_id_too_long);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [7:0] session_end_char(input int idx);
        return SESSION_END_TEXT[8 * (int'(END_TEXT_LEN) - 1 - idx) +: 8];
    endfunction

    function automatic void restart_line();
        line_phase = PH_COLUMN;
        col_count  = 0;
        text_idx   = 0;
        id_bcd     = '0;
        id_cnt     = '0;
        id_ovf     = 1'b0;
    endfunction

    function automatic void track_text_byte(input logic [7:0] b);
        t_result verdict;
        if (b == LF_BYTE) begin
            verdict = '0;
            if (line_phase == PH_TEXT && text_idx == int'(END_TEXT_LEN)) begin
                verdict.end_of_session = 1'b1;
                verdict.session_id_bcd = id_bcd;
                verdict.id_digits      = id_cnt;
                verdict.id_too_long    = id_ovf;
            end
            pending_verdicts.push_back(verdict);
            restart_line();
        end else begin
            case (line_phase)
                PH_COLUMN: begin
                    if (b == 8'h00) begin
                        line_phase = PH_REJECT;
                    end else if (col_count == int'(COL_OF_TAG)) begin
                        if (b == TAG_BYTE) line_phase = PH_PRE_WS;
                        else line_phase = PH_REJECT;
                    end
                end
                PH_PRE_WS, PH_DIGITS: begin
                    if (is_dec_digit(b)) begin
                        line_phase = PH_DIGITS;
                        id_bcd = ((id_bcd << 4) | ID_W'(b[3:0])) & ID_MASK;
                        if (id_cnt < MAX_ID_DIGITS) id_cnt++;
                        else id_ovf = 1'b1;
                    end else if (is_blank(b)) begin
                        if (line_phase == PH_DIGITS) line_phase = PH_GAP;
                    end else begin
                        line_phase = PH_REJECT;
                    end
                end
                PH_GAP: begin
                    if (!is_blank(b)) begin
                        if (b == session_end_char(0)) begin
                            line_phase = PH_TEXT;
                            text_idx   = 1;
                        end else begin
                            line_phase = PH_REJECT;
                        end
                    end
                end
                PH_TEXT: begin
                    if (text_idx < int'(END_TEXT_LEN)) begin
                        if (b == session_end_char(text_idx)) text_idx++;
                        else line_phase = PH_REJECT;
                    end else if (!is_blank(b)) begin
                        line_phase = PH_REJECT;
                    end
                end
                default: line_phase = PH_REJECT;
            endcase
            col_count++;
            if (col_count >= MAX_LINE) restart_line();
        end
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == LF_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0b;
            3:       return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    // A negative fill value gives random digits.
    function automatic void build_session_line(input int n_pre, input int n_digits,
                                               input int n_gap, input int n_tail,
                                               input int fill);
        line_bytes.delete();
        repeat (int'(COL_OF_TAG)) line_bytes.push_back(rand_text_byte());
        line_bytes.push_back(TAG_BYTE);
        repeat (n_pre) line_bytes.push_back(rand_blank());
        repeat (n_digits)
            line_bytes.push_back(8'h30 + 8'((fill < 0) ? $urandom_range(9) : fill));
        repeat (n_gap) line_bytes.push_back(rand_blank());
        for (int k = 0; k < int'(END_TEXT_LEN); k++) line_bytes.push_back(session_end_char(k));
        repeat (n_tail) line_bytes.push_back(rand_blank());
    endfunction

    function automatic void build_random_session_line();
        int n_digits;
        n_digits = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
        build_session_line($urandom_range(3), n_digits, $urandom_range(1, 3),
                           $urandom_range(3), -1);
    endfunction

    task automatic send_text_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_text_byte(b);
    endtask

    task automatic send_line(input bit with_lf);
        foreach (line_bytes[k]) send_text_byte(line_bytes[k]);
        if (with_lf) send_text_byte(LF_BYTE);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_lines();
        idle_pct  = 0;
        stall_pct = 0;
        line_bytes.delete();
        send_line(1);
        build_session_line(0, 2, 1, 0, -1);
        send_line(1);
        build_session_line(3, 5, 3, 3, -1);
        line_bytes[0] = 8'hff;
        send_line(1);
        build_session_line(0, 16, 1, 0, 9);
        send_line(1);
        build_session_line(1, 17, 2, 1, -1);
        send_line(1);
        build_session_line(0, 3, 1, 0, -1);
        line_bytes[3] = 8'h00;
        send_line(1);
        build_session_line(0, 3, 1, 0, -1);
        line_bytes.delete(0);
        send_line(1);
        build_session_line(1, 0, 1, 0, -1);
        send_line(1);
        build_session_line(0, 3, 0, 0, -1);
        send_line(1);
        build_session_line(0, 3, 1, 1, -1);
        line_bytes.push_back(8'h78);
        send_line(1);
        line_bytes.delete();
        repeat (int'(COL_OF_TAG)) line_bytes.push_back(rand_text_byte());
        send_line(1);
        line_bytes.push_back(TAG_BYTE);
        send_line(1);
        drain_results();
    endtask

    task automatic test_random_lines(input int send_idle, input int recv_stall);
        int n_bytes;
        int n_lines;
        int pick;
        int cut;
        n_bytes   = 0;
        n_lines   = 0;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        line_bytes.delete();
        repeat (3) send_line(1);
        while (n_bytes < 40) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                build_random_session_line();
            end else if (pick < 75) begin
                build_random_session_line();
                line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
            end else if (pick < 90) begin
                line_bytes.delete();
                repeat ($urandom_range(30)) line_bytes.push_back(8'($urandom_range(255)));
            end else begin
                build_random_session_line();
                cut = $urandom_range(line_bytes.size() - 1);
                while (line_bytes.size() > cut) void'(line_bytes.pop_back());
            end
            send_line(1);
            n_bytes += line_bytes.size() + 1;
            n_lines++;
            // The sender holds off once per phase until every verdict is out.
            if (n_lines == 1) drain_results();
        end
        drain_results();
    endtask

    task automatic test_partial_tail();
        idle_pct  = 25;
        stall_pct = 25;
        build_session_line(0, 3, 1, 0, -1);
        send_line(0);
    endtask

    initial begin
        restart_line();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lines();
        test_random_lines(73, 0);
        test_random_lines(0, 73);
        test_random_lines(25, 25);
        test_partial_tail();
        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("log_line_session_end_matcher_core_tb passed");
        end else begin
            $display("log_line_session_end_matcher_core_tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/llsem_pkg.sv
sv/llsem_in_reg.sv
sv/llsem_parser.sv
sv/llsem_out_reg.sv
sv/log_line_session_end_matcher_core.sv
dv/log_line_session_end_matcher_core_tb.sv
